// ===== hw/rtl/cbf_pkg.sv =====
package cbf_pkg;

    localparam int KEY_W = 64;
    localparam logic [63:0] HASH_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] HASH_PRIME = 64'h00000100000001B3;
    localparam logic [3:0] COUNT_TOP = 4'd15;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic CFG_NUM_COUNTERS = 1'b0;
    localparam logic CFG_NUM_HASHES   = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] key_bytes;
        logic [3:0]  key_length;
    } t_in_beat;

    typedef struct packed {
        logic        hit;
        logic [31:0] element_count;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MUL,
        ST_MOD,
        ST_RD,
        ST_WAIT,
        ST_UPD,
        ST_NEXT,
        ST_DONE,
        ST_OUT
    } t_state;

endpackage

// ===== hw/rtl/cbf_mod.sv =====
module cbf_mod
    import cbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    input  logic [12:0] i_modulus,
    output logic        o_done,
    output logic [12:0] o_rem
);
    logic [63:0] r_val, n_val;
    logic [12:0] r_rem, n_rem;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [13:0] w_sh;

    assign w_sh = {r_rem, r_val[63]};

    always_comb begin
        n_val  = r_val;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_val  = i_value;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_val = {r_val[62:0], 1'b0};
            if (w_sh >= {1'b0, i_modulus}) begin
                n_rem = 13'(w_sh - {1'b0, i_modulus});
            end else begin
                n_rem = w_sh[12:0];
            end
            n_cnt = 7'(r_cnt + 7'd1);
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_val <= n_val;
        r_rem <= n_rem;
    end

    assign o_done = !r_busy && !i_start;
    assign o_rem  = r_rem;
endmodule

// ===== hw/rtl/counting_bloom_filter_top.sv =====
// Counting Bloom filter with up to MAX_COUNTERS 4-bit counters in one
// single-port memory. After reset a clearing pass writes zero to every
// counter before the first item is taken. Each item hashes its key twice
// with FNV-1a (one byte and one 64-bit multiply per cycle), then for each
// of k positions forms h1+i*h2, reduces it with a shared restoring divider
// and does a counter read-modify-write. Remove runs a check pass and, only
// if every checked counter is nonzero, an update pass. A new item is taken
// only after the result of the previous one has been accepted.
module counting_bloom_filter_top
    import cbf_pkg::*;
#(
    parameter int MAX_COUNTERS = 4096,
    parameter int MAX_HASHES   = 16,
    parameter int KEY_BYTES    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_beat    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_beat   o_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    localparam int AW = $clog2(MAX_COUNTERS);
    localparam int HW = $clog2(MAX_HASHES + 1);

    t_state r_state, n_state;
    logic [12:0] r_ncnt;
    logic [4:0]  r_nhash;
    t_in_beat    r_in;
    logic [63:0] r_h1, r_h2, r_h, r_slot;
    logic        r_pass2;
    logic [3:0]  r_j;
    logic        r_second;
    logic [HW-1:0] r_i;
    logic [AW-1:0] r_clr;
    logic        r_present;
    logic [31:0] r_total;
    logic        r_hit;
    logic [3:0]  mem [MAX_COUNTERS];
    logic [3:0]  r_rd;

    logic [12:0] w_m;
    logic [HW-1:0] w_k;
    logic [3:0]  w_len;
    logic        w_mod_start, w_mod_done;
    logic [12:0] w_rem;
    logic [AW-1:0] w_addr;
    logic        w_we;
    logic [3:0]  w_wd;
    logic [63:0] w_hx;

    always_comb begin
        w_m = r_ncnt;
        if (w_m == 13'd0) w_m = 13'd1;
        if (32'(w_m) > 32'(MAX_COUNTERS)) w_m = 13'(MAX_COUNTERS);
    end

    always_comb begin
        w_k = HW'(r_nhash);
        if (r_nhash == 5'd0) w_k = HW'(1);
        if (32'(r_nhash) > 32'(MAX_HASHES)) w_k = HW'(MAX_HASHES);
    end

    assign w_len = (32'(r_in.key_length) > 32'(KEY_BYTES)) ? 4'(KEY_BYTES)
                                                           : r_in.key_length;

    assign w_hx = r_h ^ {56'd0, r_in.key_bytes[8*r_j[2:0] +: 8]};

    assign w_mod_start = (r_state == ST_MUL);

    cbf_mod u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mod_start),
        .i_value   (r_slot),
        .i_modulus (w_m),
        .o_done    (w_mod_done),
        .o_rem     (w_rem)
    );

    logic [AW-1:0] r_addr;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == AW'(MAX_COUNTERS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_valid) n_state = ST_HASH;
            ST_HASH:  if (r_second && r_j == w_len) n_state = ST_MUL;
            ST_MUL:   n_state = ST_MOD;
            ST_MOD:   if (w_mod_done) n_state = ST_RD;
            ST_RD:    n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_UPD;
            ST_UPD:   n_state = ST_NEXT;
            ST_NEXT:  n_state = (HW'(r_i + HW'(1)) == w_k) ? ST_DONE : ST_MUL;
            ST_DONE:  n_state = (r_in.mode == MODE_REMOVE && !r_pass2 && r_present)
                                ? ST_MUL : ST_OUT;
            ST_OUT:   if (i_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_data  = '{hit: r_hit, element_count: r_total};

    always_comb begin
        w_we   = 1'b0;
        w_wd   = r_rd;
        w_addr = r_addr;
        if (r_state == ST_CLEAR) begin
            w_we = 1'b1;
            w_wd = '0;
            w_addr = r_clr;
        end else if (r_state == ST_UPD) begin
            if (r_in.mode == MODE_INSERT) begin
                w_we = 1'b1;
                if (r_rd != COUNT_TOP) w_wd = 4'(r_rd + 4'd1);
            end else if (r_in.mode == MODE_REMOVE && r_pass2) begin
                w_we = 1'b1;
                if (r_rd != 4'd0 && r_rd != COUNT_TOP) w_wd = 4'(r_rd - 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_addr] <= w_wd;
        r_rd <= mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_ncnt  <= 13'd4096;
            r_nhash <= 5'd4;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= AW'(r_clr + AW'(1));
            if (i_cfg_we && i_cfg_index == CFG_NUM_COUNTERS) r_ncnt <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_NUM_HASHES) r_nhash <= i_cfg_data[4:0];
            if (r_state == ST_DONE) begin
                if (r_in.mode == MODE_INSERT && r_total != 32'hFFFFFFFF)
                    r_total <= 32'(r_total + 32'd1);
                if (r_in.mode == MODE_REMOVE && r_pass2 && r_total != 32'd0)
                    r_total <= 32'(r_total - 32'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_in <= i_data;
                r_h <= HASH_BASIS;
                r_j <= '0;
                r_second <= 1'b0;
                r_pass2 <= 1'b0;
                r_present <= 1'b1;
                r_i <= '0;
            end
            ST_HASH: begin
                if (r_j == w_len) begin
                    r_j <= '0;
                    r_second <= 1'b1;
                    if (r_second) begin
                        r_h2 <= r_h;
                        r_slot <= r_h1;
                    end else begin
                        r_h1 <= r_h;
                    end
                end else begin
                    r_h <= 64'({w_hx[23:0], 40'd0} + w_hx * {55'd0, HASH_PRIME[8:0]});
                    r_j <= 4'(r_j + 4'd1);
                end
            end
            ST_MOD: r_addr <= AW'(w_rem);
            ST_UPD: if (!r_pass2 && r_rd == 4'd0) r_present <= 1'b0;
            ST_NEXT: begin
                r_slot <= 64'(r_slot + r_h2);
                r_i <= HW'(r_i + HW'(1));
            end
            ST_DONE: begin
                r_pass2 <= 1'b1;
                r_i <= '0;
                r_slot <= r_h1;
                unique case (r_in.mode)
                    MODE_INSERT: r_hit <= 1'b1;
                    MODE_REMOVE: r_hit <= r_present;
                    MODE_QUERY:  r_hit <= r_present;
                    default:     r_hit <= 1'b0;
                endcase
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RD |-> $past(w_mod_done)) else $error("read before reduce");
endmodule

// ===== tb/cbf_checker.sv =====
module cbf_checker
    import cbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_beat    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_beat   i_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS = 4096;
    localparam int HASH_LIMIT = 16;
    localparam int KEY_LIMIT = 8;

    logic [3:0]  counters [NUM_SLOTS];
    logic [31:0] element_total;
    logic [12:0] modulus_reg;
    logic [4:0]  hashes_reg;
    t_out_beat   expected_beats [$];

    function automatic logic [63:0] fnv1a(logic [63:0] key, int len, logic [63:0] seed);
        logic [63:0] h;
        h = seed;
        for (int j = 0; j < len; j++) begin
            h = (h ^ {56'd0, key[8*j +: 8]}) * HASH_PRIME;
        end
        return h;
    endfunction

    function automatic t_out_beat apply_filter_op(t_in_beat op);
        logic [63:0] h1, h2, m, pos;
        int          k, len, slots [HASH_LIMIT];
        logic        present;
        t_out_beat   res;
        m = (modulus_reg == 0) ? 64'd1 : (modulus_reg > NUM_SLOTS) ? 64'd4096 : 64'(modulus_reg);
        k = (hashes_reg == 0) ? 1 : (hashes_reg > HASH_LIMIT) ? HASH_LIMIT : int'(hashes_reg);
        len = (op.key_length > KEY_LIMIT) ? KEY_LIMIT : int'(op.key_length);
        h1 = fnv1a(op.key_bytes, len, HASH_BASIS);
        h2 = fnv1a(op.key_bytes, len, h1);
        for (int i = 0; i < k; i++) begin
            pos = (h1 + 64'(i) * h2) % m;
            slots[i] = int'(pos);
        end
        res.hit = 1'b0;
        case (op.mode)
            MODE_INSERT: begin
                for (int i = 0; i < k; i++) begin
                    if (counters[slots[i]] < COUNT_TOP) counters[slots[i]]++;
                end
                if (element_total != 32'hFFFF_FFFF) element_total++;
                res.hit = 1'b1;
            end
            MODE_REMOVE, MODE_QUERY: begin
                present = 1'b1;
                for (int i = 0; i < k; i++) begin
                    if (counters[slots[i]] == 0) present = 1'b0;
                end
                if (op.mode == MODE_QUERY) begin
                    res.hit = present;
                end else if (present) begin
                    for (int i = 0; i < k; i++) begin
                        if (counters[slots[i]] != 0 && counters[slots[i]] != COUNT_TOP)
                            counters[slots[i]]--;
                    end
                    if (element_total != 0) element_total--;
                    res.hit = 1'b1;
                end
            end
            default: ;
        endcase
        res.element_count = element_total;
        return res;
    endfunction

    assign o_pending = expected_beats.size();

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            foreach (counters[i]) counters[i] = 4'd0;
            element_total = 32'd0;
            modulus_reg = 13'd4096;
            hashes_reg = 5'd4;
            expected_beats.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_NUM_COUNTERS) modulus_reg = i_cfg_data;
                else hashes_reg = i_cfg_data[4:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected result beat: hit=%0b element_count=%0d",
                           i_out_data.hit, i_out_data.element_count);
                    o_errors++;
                end else begin
                    want = expected_beats.pop_front();
                    if (want.hit !== i_out_data.hit) begin
                        $error("hit: expected %0b, actual %0b", want.hit, i_out_data.hit);
                        o_errors++;
                    end
                    if (want.element_count !== i_out_data.element_count) begin
                        $error("element_count: expected %0d, actual %0d",
                               want.element_count, i_out_data.element_count);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) expected_beats.push_back(apply_filter_op(i_in_data));
        end
    end
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import cbf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_beat    i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_beat   o_data;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_NUM_COUNTERS;
    logic [12:0] i_cfg_data = '0;
    int          error_count, pending_count;
    int          stall_pct = 0;
    int          burst_left = 0;
    int          max_gap = 0;
    int          items_sent = 0;
    int          settings_run = 0;
    logic [63:0] key_pool [16];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    counting_bloom_filter_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    cbf_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(error_count), .o_pending(pending_count)
    );

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_op(logic [1:0] mode, logic [63:0] key, logic [3:0] len);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data <= '{mode: mode, key_bytes: key, key_length: len};
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        items_sent++;
        if (burst_left == 0) i_valid <= 1'b0;
    endtask

    task automatic drain_and_idle();
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (pending_count != 0 || !o_ready) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [12:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count);
        logic [1:0]  mode;
        logic [63:0] key;
        int          r;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            mode = (r < 40) ? MODE_INSERT : (r < 65) ? MODE_REMOVE : (r < 95) ? MODE_QUERY : 2'd3;
            key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 15)]
                                             : {$urandom, $urandom};
            send_op(mode, key, 4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        int m_vals [8] = '{4096, 1, 0, 8191, 16, 4096, 64, 300};
        int k_vals [8] = '{4, 1, 0, 31, 16, 16, 3, 2};
        int n_vals [8] = '{160, 160, 120, 40, 50, 40, 200, 200};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_cfg(CFG_NUM_COUNTERS, 13'd4096);
        write_cfg(CFG_NUM_HASHES, 13'd4);

        send_op(MODE_QUERY, 64'd0, 4'd0);
        send_op(MODE_REMOVE, 64'd0, 4'd0);
        send_op(MODE_INSERT, 64'd0, 4'd0);
        send_op(MODE_QUERY, 64'd0, 4'd0);
        send_op(MODE_INSERT, '1, 4'd8);
        send_op(MODE_QUERY, '1, 4'd15);
        send_op(MODE_INSERT, 64'h0123_4567_89AB_CDEF, 4'd12);
        send_op(MODE_QUERY, 64'h0123_4567_89AB_CDEF, 4'd8);
        send_op(2'd3, '1, 4'd15);
        send_op(MODE_REMOVE, '1, 4'd8);
        send_op(MODE_QUERY, '1, 4'd8);
        send_op(MODE_REMOVE, 64'hDEAD_BEEF, 4'd4);
        send_op(MODE_REMOVE, 64'd0, 4'd0);
        send_op(MODE_REMOVE, 64'd0, 4'd0);
        send_op(MODE_INSERT, 64'h8000_0000_0000_0001, 4'd1);
        send_op(MODE_INSERT, 64'h8000_0000_0000_0001, 4'd8);
        drain_and_idle();
        write_cfg(CFG_NUM_COUNTERS, 13'd1);
        for (int i = 0; i < 17; i++) send_op(MODE_INSERT, 64'(i), 4'd1);
        send_op(MODE_REMOVE, 64'd5, 4'd1);
        send_op(MODE_QUERY, 64'd99, 4'd2);
        drain_and_idle();

        for (int p = 0; p < 8; p++) begin
            write_cfg(CFG_NUM_COUNTERS, 13'(m_vals[p]));
            write_cfg(CFG_NUM_HASHES, 13'(k_vals[p]));
            stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 70);
            max_gap = (p % 4 == 1) ? 0 : $urandom_range(2, 20);
            run_random(n_vals[p]);
            drain_and_idle();
            settings_run++;
        end

        repeat (200) @(posedge i_clk);
        $display("Sent %0d operations (insert/remove/query/unused) with keys of 0 to 15 bytes,",
                 items_sent);
        $display("over %0d random register settings including modulus and hash-count extremes.",
                 settings_run);
        if (error_count == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
